>>> sv/otst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package otst_pkg;

  localparam int unsigned SLOTS_DEF = 32;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned TAG_W     = 32;
  localparam int unsigned HANDLE_W  = 6;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 2;

  // Input beat layout, lowest bit first.
  localparam int unsigned IN_NOW_LO     = 0;
  localparam int unsigned IN_DELAY_LO   = IN_NOW_LO + TICK_W;
  localparam int unsigned IN_HANDLE_LO  = IN_DELAY_LO + TICK_W;
  localparam int unsigned IN_HANDLER_LO = IN_HANDLE_LO + HANDLE_W;
  localparam int unsigned IN_PARAM_LO   = IN_HANDLER_LO + TAG_W;
  localparam int unsigned IN_CONTEXT_LO = IN_PARAM_LO + TAG_W;
  localparam int unsigned IN_BITS       = IN_CONTEXT_LO + TAG_W;
  localparam int unsigned IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output beat layout, lowest bit first.
  localparam int unsigned OUT_HANDLE_LO  = 0;
  localparam int unsigned OUT_HANDLER_LO = OUT_HANDLE_LO + HANDLE_W;
  localparam int unsigned OUT_PARAM_LO   = OUT_HANDLER_LO + TAG_W;
  localparam int unsigned OUT_CONTEXT_LO = OUT_PARAM_LO + TAG_W;
  localparam int unsigned OUT_BITS       = OUT_CONTEXT_LO + TAG_W;
  localparam int unsigned OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_START      = 2'd0,
    OP_CANCEL     = 2'd1,
    OP_CANCEL_ALL = 2'd2,
    OP_UPDATE     = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  // One slot of the timer table as stored in memory.
  typedef struct packed {
    logic [TAG_W-1:0]  context_tag;
    logic [TAG_W-1:0]  param_tag;
    logic [TAG_W-1:0]  handler_tag;
    logic [TICK_W-1:0] deadline;
  } entry_t;

endpackage

`default_nettype wire

>>> sv/otst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module otst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/otst_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared 32-bit adder. It forms the deadline of a new timer and the
// remaining time of a stored one, and flags a remaining time that is
// zero or negative.
module otst_alu (
  input  wire logic [otst_pkg::TICK_W-1:0] a_i,
  input  wire logic [otst_pkg::TICK_W-1:0] b_i,
  input  wire logic                        sub_i,
  output logic      [otst_pkg::TICK_W-1:0] sum_o,
  output logic                             due_o
);

  logic [otst_pkg::TICK_W-1:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_op + otst_pkg::TICK_W'(sub_i);
  assign due_o = (sum_o == '0) || sum_o[otst_pkg::TICK_W-1];

endmodule

`default_nettype wire

>>> sv/oneshot_timer_slot_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One-shot timer slot table.
// The input stream carries one operation per beat: tuser holds the opcode
// (start, cancel, cancel all, update) and tdata the tick, delay, handle and
// three tags. The output stream returns result beats: tuser holds the kind
// (start reply, timer expired, done), tlast marks the final beat of an
// operation. A start replies with handle slot+1 or 0 when the table is full.
// An update returns one beat per expired timer in slot order, then a done.
// The block takes one operation at a time and drops tready until the final
// beat of that operation sits in the output register.
// After accept, a start runs a free-slot scan that passes the busy slots in
// slot order and then loads its reply; cancel and cancel all go straight to
// their reply; an update scans every slot and then loads its done beat.
// The slot scan examines one slot per cycle through one memory read port and
// one shared adder. When the receiver stalls, the scan holds on an expired
// slot, and the closing beat waits, until the output register frees.
// Reset frees every slot and empties the output register; stored deadlines
// and tags are not cleared, since only the contents of busy slots are ever used.
module oneshot_timer_slot_table_core #(
  parameter int unsigned SLOTS = otst_pkg::SLOTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // now_tick, delay, handle, handler_tag, param_tag, context_tag, zero pad
  input  wire logic [otst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  wire logic [otst_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // result_handle, out_handler, out_param, out_context, zero pad
  output logic      [otst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // kind
  output logic      [otst_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                                    m_axis_tlast
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                          state_q;
  logic [IDX_W-1:0]                idx_q;
  logic [SLOTS-1:0]                busy_q;
  otst_pkg::kind_e                 resp_kind_q;
  logic [otst_pkg::HANDLE_W-1:0]   resp_handle_q;

  logic                            out_valid_q;
  otst_pkg::kind_e                 out_kind_q;
  logic [otst_pkg::HANDLE_W-1:0]   out_handle_q;
  logic [otst_pkg::TAG_W-1:0]      out_handler_q;
  logic [otst_pkg::TAG_W-1:0]      out_param_q;
  logic [otst_pkg::TAG_W-1:0]      out_context_q;
  logic                            out_last_q;

  logic [otst_pkg::TICK_W-1:0]     now_q;
  logic [otst_pkg::TICK_W-1:0]     delay_q;
  logic [otst_pkg::TAG_W-1:0]      handler_q;
  logic [otst_pkg::TAG_W-1:0]      param_q;
  logic [otst_pkg::TAG_W-1:0]      context_q;

  logic                            in_fire;
  otst_pkg::op_e                   in_op;
  logic [otst_pkg::HANDLE_W-1:0]   in_handle;
  logic                            cancel_ok;
  logic [IDX_W-1:0]                cancel_idx;
  logic                            out_free;
  logic                            out_load;
  logic                            idx_last;
  logic                            cur_busy;

  otst_pkg::entry_t                ram_wdata;
  otst_pkg::entry_t                ram_rdata;
  logic                            ram_we;
  logic                            ram_re;
  logic [IDX_W-1:0]                ram_raddr;

  logic                            scan_mode;
  logic [otst_pkg::TICK_W-1:0]     alu_a;
  logic [otst_pkg::TICK_W-1:0]     alu_b;
  logic [otst_pkg::TICK_W-1:0]     alu_sum;
  logic                            alu_due;
  logic                            expire;
  logic                            scan_step;

  function automatic logic [otst_pkg::HANDLE_W-1:0] handle_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] h;
    h = {1'b0, idx} + (IDX_W+1)'(1);
    return otst_pkg::HANDLE_W'(h);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = otst_pkg::op_e'(s_axis_tuser);
  assign in_handle     = s_axis_tdata[otst_pkg::IN_HANDLE_LO +: otst_pkg::HANDLE_W];
  assign cancel_ok     = (in_handle != '0) && (32'(in_handle) <= 32'(SLOTS));
  assign cancel_idx    = IDX_W'(in_handle - otst_pkg::HANDLE_W'(1));

  assign out_free  = !out_valid_q || m_axis_tready;
  assign idx_last  = (idx_q == IDX_W'(SLOTS - 1));
  assign cur_busy  = busy_q[idx_q];

  // The adder builds now + delay while searching, and deadline - now while scanning.
  assign scan_mode = (state_q == ST_SCAN);
  assign alu_a     = scan_mode ? ram_rdata.deadline : now_q;
  assign alu_b     = scan_mode ? now_q : delay_q;

  otst_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (scan_mode),
    .sum_o (alu_sum),
    .due_o (alu_due)
  );

  assign expire    = cur_busy && alu_due;
  assign scan_step = !expire || out_free;

  // The output register is loaded by an expired slot or by the closing beat.
  assign out_load  = (scan_mode && scan_step && expire) ||
                     ((state_q == ST_RESP) && out_free);

  assign ram_we                = (state_q == ST_FIND) && !cur_busy;
  assign ram_wdata.deadline    = alu_sum;
  assign ram_wdata.handler_tag = handler_q;
  assign ram_wdata.param_tag   = param_q;
  assign ram_wdata.context_tag = context_q;

  // The read for the next slot is issued while the current one is checked.
  assign ram_re    = (in_fire && (in_op == otst_pkg::OP_UPDATE)) ||
                     (scan_mode && scan_step && !idx_last);
  assign ram_raddr = scan_mode ? idx_q + IDX_W'(1) : '0;

  otst_ram #(
    .WIDTH ($bits(otst_pkg::entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q     <= s_axis_tdata[otst_pkg::IN_NOW_LO +: otst_pkg::TICK_W];
      delay_q   <= s_axis_tdata[otst_pkg::IN_DELAY_LO +: otst_pkg::TICK_W];
      handler_q <= s_axis_tdata[otst_pkg::IN_HANDLER_LO +: otst_pkg::TAG_W];
      param_q   <= s_axis_tdata[otst_pkg::IN_PARAM_LO +: otst_pkg::TAG_W];
      context_q <= s_axis_tdata[otst_pkg::IN_CONTEXT_LO +: otst_pkg::TAG_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      busy_q        <= '0;
      resp_kind_q   <= otst_pkg::KIND_DONE;
      resp_handle_q <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= otst_pkg::KIND_DONE;
      out_handle_q  <= '0;
      out_handler_q <= '0;
      out_param_q   <= '0;
      out_context_q <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            idx_q         <= '0;
            resp_kind_q   <= otst_pkg::KIND_DONE;
            resp_handle_q <= '0;
            unique case (in_op)
              otst_pkg::OP_START: begin
                state_q <= ST_FIND;
              end
              otst_pkg::OP_CANCEL: begin
                if (cancel_ok) begin
                  busy_q[cancel_idx] <= 1'b0;
                end
                state_q <= ST_RESP;
              end
              otst_pkg::OP_CANCEL_ALL: begin
                busy_q  <= '0;
                state_q <= ST_RESP;
              end
              otst_pkg::OP_UPDATE: begin
                state_q <= ST_SCAN;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_FIND: begin
          resp_kind_q <= otst_pkg::KIND_START;
          if (!cur_busy) begin
            busy_q[idx_q] <= 1'b1;
            resp_handle_q <= handle_of(idx_q);
            state_q       <= ST_RESP;
          end else if (idx_last) begin
            resp_handle_q <= '0;
            state_q       <= ST_RESP;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            if (expire) begin
              busy_q[idx_q] <= 1'b0;
              out_kind_q    <= otst_pkg::KIND_EXPIRED;
              out_handle_q  <= handle_of(idx_q);
              out_handler_q <= ram_rdata.handler_tag;
              out_param_q   <= ram_rdata.param_tag;
              out_context_q <= ram_rdata.context_tag;
              out_last_q    <= 1'b0;
            end
            if (idx_last) begin
              state_q <= ST_RESP;
            end else begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_kind_q    <= resp_kind_q;
            out_handle_q  <= resp_handle_q;
            out_handler_q <= '0;
            out_param_q   <= '0;
            out_context_q <= '0;
            out_last_q    <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = otst_pkg::OUT_TDATA_W'({out_context_q, out_param_q,
                                                 out_handler_q, out_handle_q});

  // An expired-timer beat never closes an operation; every other kind does.
  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == otst_pkg::KIND_EXPIRED) |-> !m_axis_tlast)
    else $error("expired beat marked last");

  a_last_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tuser == otst_pkg::KIND_EXPIRED))
    else $error("non-expired beat without last");

  // A reported timer is freed at the same time.
  a_expire_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && expire && scan_step |=> !busy_q[$past(idx_q)])
    else $error("expired slot still busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("second operation accepted back to back");

endmodule

`default_nettype wire

>>> test/oneshot_timer_slot_table_core_tb.sv
`timescale 1ns / 1ps

module oneshot_timer_slot_table_core_tb;

  localparam int unsigned NSLOTS = otst_pkg::SLOTS_DEF;
  localparam int unsigned ITEMS_PER_PHASE = 30;

  typedef struct {
    otst_pkg::kind_e                kind;
    logic [otst_pkg::HANDLE_W-1:0]  handle;
    logic [otst_pkg::TAG_W-1:0]     handler;
    logic [otst_pkg::TAG_W-1:0]     param;
    logic [otst_pkg::TAG_W-1:0]     ctx;
    logic                           last;
  } timer_beat_t;

  // Keeps a shadow copy of the slot table and the beats the block owes us.
  class timer_scoreboard;
    bit                          slot_used[NSLOTS];
    logic [otst_pkg::TICK_W-1:0] slot_due[NSLOTS];
    logic [otst_pkg::TAG_W-1:0]  slot_handler[NSLOTS];
    logic [otst_pkg::TAG_W-1:0]  slot_param[NSLOTS];
    logic [otst_pkg::TAG_W-1:0]  slot_ctx[NSLOTS];
    timer_beat_t                 expected_beats[$];
    int unsigned                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
    endfunction

    function void push_beat(otst_pkg::kind_e kind, int unsigned handle,
                            logic [otst_pkg::TAG_W-1:0] hd,
                            logic [otst_pkg::TAG_W-1:0] pr,
                            logic [otst_pkg::TAG_W-1:0] cx, logic last);
      timer_beat_t b;
      b.kind    = kind;
      b.handle  = handle[otst_pkg::HANDLE_W-1:0];
      b.handler = hd;
      b.param   = pr;
      b.ctx     = cx;
      b.last    = last;
      expected_beats.push_back(b);
    endfunction

    function void note_op(otst_pkg::op_e op, logic [otst_pkg::TICK_W-1:0] now,
                          logic [otst_pkg::TICK_W-1:0] delay,
                          logic [otst_pkg::HANDLE_W-1:0] handle,
                          logic [otst_pkg::TAG_W-1:0] hd,
                          logic [otst_pkg::TAG_W-1:0] pr,
                          logic [otst_pkg::TAG_W-1:0] cx);
      int                          free_slot;
      logic [otst_pkg::TICK_W-1:0] diff;
      free_slot = -1;
      case (op)
        otst_pkg::OP_START: begin
          for (int i = 0; i < NSLOTS; i++) begin
            if (free_slot < 0 && !slot_used[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            slot_used[free_slot]    = 1'b1;
            slot_due[free_slot]     = now + delay;
            slot_handler[free_slot] = hd;
            slot_param[free_slot]   = pr;
            slot_ctx[free_slot]     = cx;
          end
          push_beat(otst_pkg::KIND_START, free_slot + 1, '0, '0, '0, 1'b1);
        end
        otst_pkg::OP_CANCEL: begin
          if (handle >= 1 && handle <= NSLOTS) slot_used[handle - 1] = 1'b0;
          push_beat(otst_pkg::KIND_DONE, 0, '0, '0, '0, 1'b1);
        end
        otst_pkg::OP_CANCEL_ALL: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          push_beat(otst_pkg::KIND_DONE, 0, '0, '0, '0, 1'b1);
        end
        default: begin
          for (int i = 0; i < NSLOTS; i++) begin
            diff = slot_due[i] - now;
            // A deadline at or behind the current tick, read as signed, is due.
            if (slot_used[i] && (diff == '0 || diff[otst_pkg::TICK_W-1])) begin
              push_beat(otst_pkg::KIND_EXPIRED, i + 1, slot_handler[i], slot_param[i],
                        slot_ctx[i], 1'b0);
              slot_used[i] = 1'b0;
            end
          end
          push_beat(otst_pkg::KIND_DONE, 0, '0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [otst_pkg::TAG_W-1:0] exp_v,
                                logic [otst_pkg::TAG_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [otst_pkg::KIND_W-1:0] kind,
                             logic [otst_pkg::HANDLE_W-1:0] handle,
                             logic [otst_pkg::TAG_W-1:0] hd,
                             logic [otst_pkg::TAG_W-1:0] pr,
                             logic [otst_pkg::TAG_W-1:0] cx, logic last);
      timer_beat_t b;
      if (expected_beats.size() == 0) begin
        $error("result beat with no outstanding expectation: kind %0d handle %0d",
               kind, handle);
        mismatches++;
      end else begin
        b = expected_beats.pop_front();
        compare_field("kind", b.kind, kind);
        compare_field("result_handle", b.handle, handle);
        compare_field("out_handler", b.handler, hd);
        compare_field("out_param", b.param, pr);
        compare_field("out_context", b.ctx, cx);
        compare_field("last", b.last, last);
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [otst_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [otst_pkg::OP_W-1:0]        s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [otst_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [otst_pkg::KIND_W-1:0]      m_axis_tuser;
  logic                             m_axis_tlast;

  timer_scoreboard             sb;
  int unsigned                 src_idle_pct;
  int unsigned                 sink_stall_pct;
  logic [otst_pkg::TICK_W-1:0] tick_now;

  oneshot_timer_slot_table_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_beat(m_axis_tuser,
                    m_axis_tdata[otst_pkg::OUT_HANDLE_LO +: otst_pkg::HANDLE_W],
                    m_axis_tdata[otst_pkg::OUT_HANDLER_LO +: otst_pkg::TAG_W],
                    m_axis_tdata[otst_pkg::OUT_PARAM_LO +: otst_pkg::TAG_W],
                    m_axis_tdata[otst_pkg::OUT_CONTEXT_LO +: otst_pkg::TAG_W],
                    m_axis_tlast);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_op(otst_pkg::op_e op, logic [otst_pkg::TICK_W-1:0] now,
                         logic [otst_pkg::TICK_W-1:0] delay,
                         logic [otst_pkg::HANDLE_W-1:0] handle,
                         logic [otst_pkg::TAG_W-1:0] hd,
                         logic [otst_pkg::TAG_W-1:0] pr,
                         logic [otst_pkg::TAG_W-1:0] cx);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = otst_pkg::IN_TDATA_W'({$urandom(), $urandom(), $urandom(),
                                             $urandom(), $urandom(), $urandom()});
      s_axis_tuser  = otst_pkg::OP_W'($urandom_range(3));
      @(negedge clk_i);
    end
    s_axis_tdata                                                   = '0;
    s_axis_tdata[otst_pkg::IN_NOW_LO +: otst_pkg::TICK_W]          = now;
    s_axis_tdata[otst_pkg::IN_DELAY_LO +: otst_pkg::TICK_W]        = delay;
    s_axis_tdata[otst_pkg::IN_HANDLE_LO +: otst_pkg::HANDLE_W]     = handle;
    s_axis_tdata[otst_pkg::IN_HANDLER_LO +: otst_pkg::TAG_W]       = hd;
    s_axis_tdata[otst_pkg::IN_PARAM_LO +: otst_pkg::TAG_W]         = pr;
    s_axis_tdata[otst_pkg::IN_CONTEXT_LO +: otst_pkg::TAG_W]       = cx;
    s_axis_tuser                                                   = op;
    s_axis_tvalid                                                  = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_op(op, now, delay, handle, hd, pr, cx);
    @(negedge clk_i);
  endtask

  task automatic send_random_op();
    int unsigned                   pick;
    otst_pkg::op_e                 op;
    logic [otst_pkg::TICK_W-1:0]   delay;
    logic [otst_pkg::HANDLE_W-1:0] handle;
    logic [otst_pkg::TAG_W-1:0]    hd;
    pick = $urandom_range(99);
    if (pick < 50)      op = otst_pkg::OP_START;
    else if (pick < 70) op = otst_pkg::OP_CANCEL;
    else if (pick < 75) op = otst_pkg::OP_CANCEL_ALL;
    else                op = otst_pkg::OP_UPDATE;
    if ($urandom_range(9) == 0) tick_now = $urandom();
    else                        tick_now = tick_now + $urandom_range(50);
    pick = $urandom_range(99);
    if (pick < 70)      delay = $urandom_range(300);
    else if (pick < 85) delay = '0;
    else                delay = $urandom();
    if ($urandom_range(3) == 0) handle = otst_pkg::HANDLE_W'($urandom_range(63));
    else                        handle = otst_pkg::HANDLE_W'($urandom_range(NSLOTS, 1));
    hd = ($urandom_range(9) == 0) ? '0 : $urandom();
    send_op(op, tick_now, delay, handle, hd, $urandom(), $urandom());
  endtask

  // Fills the table past full with far deadlines, then exercises the top handle.
  task automatic fill_table();
    for (int i = 0; i < NSLOTS + 2; i++) begin
      send_op(otst_pkg::OP_START, tick_now, $urandom_range(100000, 1000),
              otst_pkg::HANDLE_W'($urandom()), $urandom(), $urandom(), $urandom());
    end
    send_op(otst_pkg::OP_CANCEL, tick_now, $urandom(), otst_pkg::HANDLE_W'(NSLOTS),
            $urandom(), $urandom(), $urandom());
    send_op(otst_pkg::OP_START, tick_now, $urandom_range(100000, 1000),
            otst_pkg::HANDLE_W'($urandom()), $urandom(), $urandom(), $urandom());
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
    repeat (NSLOTS + 8) @(negedge clk_i);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = otst_pkg::OP_START;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    tick_now       = '0;
    sb             = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, bad handles, tick wrap, zero handler tag, cancel all.
    send_op(otst_pkg::OP_UPDATE, 32'h0, '0, '0, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'h0, '0, 6'd0, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'h0, '0, 6'd63, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'h0, '0, 6'd33, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'h0, '0, 6'd5, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'h0, '0, 6'd32, '0, '0, '0);
    send_op(otst_pkg::OP_START, 32'hFFFF_FFFF, 32'h0, '0, 32'h0, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);
    send_op(otst_pkg::OP_START, 32'hFFFF_FFF0, 32'h20, 6'd63, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(otst_pkg::OP_START, 32'h0, 32'hFFFF_FFFF, '0, 32'h0, 32'h0, 32'h0);
    send_op(otst_pkg::OP_START, 32'd100, 32'h7FFF_FFFF, '0, 32'h1234_5678,
            32'h9ABC_DEF0, 32'h0F0F_0F0F);
    send_op(otst_pkg::OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(otst_pkg::OP_START, 32'd5, 32'd1, '0, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
            32'hC3C3_C3C3);
    send_op(otst_pkg::OP_CANCEL, 32'd5, '0, 6'd2, '0, '0, '0);
    send_op(otst_pkg::OP_CANCEL, 32'd5, '0, 6'd2, '0, '0, '0);
    send_op(otst_pkg::OP_UPDATE, 32'd5, '0, '0, '0, '0, '0);
    send_op(otst_pkg::OP_UPDATE, 32'd6, '0, '0, '0, '0, '0);
    for (int i = 0; i < 3; i++) begin
      send_op(otst_pkg::OP_START, 32'd10, 32'd0, '0, $urandom(), $urandom(), $urandom());
    end
    send_op(otst_pkg::OP_CANCEL_ALL, 32'd10, '0, '0, '0, '0, '0);
    send_op(otst_pkg::OP_UPDATE, 32'hFFFF_FFFF, '0, '0, '0, '0, '0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 19; sink_stall_pct = 19; end
      endcase
      if (phase == 1) fill_table();
      repeat (ITEMS_PER_PHASE) send_random_op();
      // The sender holds off here until every owed beat has come back.
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/otst_pkg.sv
sv/otst_ram.sv
sv/otst_alu.sv
sv/oneshot_timer_slot_table_core.sv
test/oneshot_timer_slot_table_core_tb.sv
